### src/rgx_pkg.sv
// shared types, constants and register codes for the rle glyph expander
`default_nettype none
package rgx_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned RUN_W        = 7;
	localparam int unsigned POS_W        = 16;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned DIV_BITS     = 2;
	localparam int unsigned DIV_ITERS    = POS_W / DIV_BITS;
	localparam int unsigned DIV_CNT_W    = $clog2(DIV_ITERS);

	localparam logic [BYTE_W-1:0] PIX_ALL      = 8'hFF;
	localparam logic [RUN_W-1:0]  RUN_MASK     = 7'h7F;
	localparam int unsigned       LITERAL_BIT  = 7;

	localparam logic [BYTE_W-1:0] GW_RESET  = 8'd8;
	localparam logic [BYTE_W-1:0] VW_RESET  = 8'd8;
	localparam logic [BYTE_W-1:0] RC_RESET  = 8'd1;
	localparam logic              INV_RESET = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLYPH_WIDTH   = 2'd0,
		REG_VISIBLE_WIDTH = 2'd1,
		REG_ROW_COUNT     = 2'd2,
		REG_INVERT        = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              start_glyph;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pixel_byte;
		logic [POS_W-1:0]  repeat_count;
		logic              glyph_done;
		logic              bad_data;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] glyph_width;
		logic [BYTE_W-1:0] visible_width;
		logic [BYTE_W-1:0] row_count;
		logic              invert;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DECODE,
		ST_WRAP,
		ST_PART,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic start;
		logic decode;
		logic wrap;
		logic part;
		logic div_step;
		logic mul;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic header_only;
		logic div_skip;
		logic div_last;
		logic slot_free;
	} dp_status_t;

endpackage
`default_nettype wire

### src/rgx_ctrl.sv
// controller state machine sequencing one request through the datapath
`default_nettype none
module rgx_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  rgx_pkg::dp_status_t status,
	output rgx_pkg::dp_cmd_t    cmd
);
	import rgx_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_next = ST_START;
			end
			ST_START: state_next = ST_DECODE;
			ST_DECODE: begin
				if (!status.active || status.header_only) state_next = ST_IDLE;
				else state_next = ST_WRAP;
			end
			ST_WRAP: state_next = ST_PART;
			ST_PART: state_next = ST_DIV;
			ST_DIV: begin
				if (status.div_skip) state_next = ST_OUT;
				else if (status.div_last) state_next = ST_MUL;
			end
			ST_MUL: state_next = ST_OUT;
			ST_OUT: begin
				if (status.slot_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.load_in = item_valid;
			end
			ST_START:  cmd.start    = 1'b1;
			ST_DECODE: cmd.decode   = status.active;
			ST_WRAP:   cmd.wrap     = 1'b1;
			ST_PART:   cmd.part     = 1'b1;
			ST_DIV:    cmd.div_step = !status.div_skip;
			ST_MUL:    cmd.mul      = 1'b1;
			ST_OUT:    cmd.fin      = status.slot_free;
			default: begin
				cmd        = '0;
				item_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/rgx_dp.sv
// datapath: run and position state, column coverage, divider and result register
`default_nettype none
module rgx_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  rgx_pkg::item_t      item,
	input  rgx_pkg::cfg_t       cfg,
	input  rgx_pkg::dp_cmd_t    cmd,
	output rgx_pkg::dp_status_t status,
	output rgx_pkg::result_t    result,
	output logic                result_valid,
	input  wire                 result_ready
);
	import rgx_pkg::*;

	logic [BYTE_W-1:0]    code_q;
	logic                 start_q;
	logic [RUN_W-1:0]     run_left_q;
	logic                 repeat_q;
	logic [BYTE_W-1:0]    col_q;
	logic [POS_W-1:0]     pos_left_q;
	logic                 active_q;
	logic [POS_W-1:0]     n_q;
	logic [POS_W-1:0]     n_orig_q;
	logic [POS_W-1:0]     total_q;
	logic [BYTE_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 bad_q;
	result_t              result_q;
	logic                 result_valid_q;

	logic [BYTE_W-1:0]    vis;
	logic [BYTE_W-1:0]    inv_mask;
	logic [POS_W-1:0]     glyph_size;
	logic [POS_W-1:0]     run_ext;
	logic [POS_W-1:0]     run_n;
	logic [BYTE_W-1:0]    room;
	logic [POS_W-1:0]     k;
	logic [BYTE_W:0]      ck;
	logic [BYTE_W:0]      ck_clip;
	logic [BYTE_W:0]      part_vis;
	logic                 part_do;
	logic [BYTE_W-1:0]    dv_r;
	logic [POS_W-1:0]     dv_q;
	logic [BYTE_W:0]      dv_t;
	logic [POS_W+BYTE_W-1:0] mul_full;
	logic [BYTE_W-1:0]    rem_vis;
	logic [POS_W-1:0]     pos_next;
	logic                 slot_free;

	// visible columns saturate at the row width
	assign vis        = (cfg.visible_width < cfg.glyph_width) ? cfg.visible_width
	                                                          : cfg.glyph_width;
	assign inv_mask   = {BYTE_W{cfg.invert}};
	assign glyph_size = {{(POS_W-BYTE_W){1'b0}}, cfg.glyph_width}
	                  * {{(POS_W-BYTE_W){1'b0}}, cfg.row_count};
	assign run_ext    = {{(POS_W-RUN_W){1'b0}}, run_left_q};
	assign run_n      = (run_ext < pos_left_q) ? run_ext : pos_left_q;

	// partial first row
	assign room     = cfg.glyph_width - col_q;
	assign k        = ({{(POS_W-BYTE_W){1'b0}}, room} < n_q)
	                  ? {{(POS_W-BYTE_W){1'b0}}, room} : n_q;
	assign ck       = {1'b0, col_q} + {1'b0, k[BYTE_W-1:0]};
	assign ck_clip  = (ck < {1'b0, vis}) ? ck : {1'b0, vis};
	assign part_vis = (col_q < vis) ? (ck_clip - {1'b0, col_q}) : '0;
	assign part_do  = (cfg.glyph_width != '0) && (n_q != '0) && (col_q != '0);

	// restoring division, two quotient bits per step
	always_comb begin
		dv_r = rem_q;
		dv_q = n_q;
		dv_t = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			dv_t = {dv_r, dv_q[POS_W-1]};
			dv_q = {dv_q[POS_W-2:0], 1'b0};
			if (dv_t >= {1'b0, cfg.glyph_width}) begin
				dv_t    = dv_t - {1'b0, cfg.glyph_width};
				dv_q[0] = 1'b1;
			end
			dv_r = dv_t[BYTE_W-1:0];
		end
	end

	assign mul_full = {{BYTE_W{1'b0}}, n_q} * {{POS_W{1'b0}}, vis};
	assign rem_vis  = (rem_q < vis) ? rem_q : vis;
	assign pos_next = pos_left_q - n_orig_q;
	assign slot_free = !result_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			code_q  <= item.code_byte;
			start_q <= item.start_glyph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_left_q <= '0;
			repeat_q   <= 1'b0;
			col_q      <= '0;
			pos_left_q <= '0;
			active_q   <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cmd.start && start_q) begin
				run_left_q <= '0;
				repeat_q   <= 1'b0;
				col_q      <= '0;
				pos_left_q <= glyph_size;
				active_q   <= (glyph_size != '0);
			end
			if (cmd.decode) begin
				if (run_left_q == '0) begin
					repeat_q <= !code_q[LITERAL_BIT] && (code_q[RUN_W-1:0] != '0);
					run_left_q <= code_q[RUN_W-1:0] & RUN_MASK;
				end else if (repeat_q) begin
					run_left_q <= '0;
				end else begin
					run_left_q <= run_left_q - 1'b1;
				end
			end
			if (cmd.wrap) begin
				if ((n_q != '0) && (col_q >= cfg.glyph_width)) col_q <= '0;
			end
			if (cmd.part) begin
				div_cnt_q <= '0;
				if (part_do) col_q <= (ck >= {1'b0, cfg.glyph_width}) ? '0
				                                                    : ck[BYTE_W-1:0];
			end
			if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.mul) col_q <= rem_q;
			if (cmd.fin) begin
				pos_left_q <= pos_next;
				if (pos_next == '0) begin
					active_q   <= 1'b0;
					run_left_q <= '0;
					repeat_q   <= 1'b0;
				end
			end
		end
	end

	// work registers of the coverage computation
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			total_q <= '0;
			if (run_left_q == '0) begin
				n_q      <= pos_left_q;
				n_orig_q <= pos_left_q;
				bad_q    <= (code_q[RUN_W-1:0] == '0);
			end else begin
				bad_q <= 1'b0;
				if (repeat_q) begin
					n_q      <= run_n;
					n_orig_q <= run_n;
				end else begin
					n_q      <= {{(POS_W-1){1'b0}}, 1'b1};
					n_orig_q <= {{(POS_W-1){1'b0}}, 1'b1};
				end
			end
		end
		if (cmd.wrap) begin
			if ((n_q != '0) && (col_q >= cfg.glyph_width)) n_q <= n_q - 1'b1;
		end
		if (cmd.part) begin
			rem_q <= '0;
			if (part_do) begin
				n_q     <= n_q - k;
				total_q <= total_q + {{(POS_W-BYTE_W){1'b0}}, part_vis[BYTE_W-1:0]};
			end
		end
		if (cmd.div_step) begin
			n_q   <= dv_q;
			rem_q <= dv_r;
		end
		if (cmd.mul) begin
			total_q <= total_q + mul_full[POS_W-1:0]
			         + {{(POS_W-BYTE_W){1'b0}}, rem_vis};
		end
		if (cmd.fin) begin
			result_q.pixel_byte   <= (bad_q ? PIX_ALL : code_q) ^ inv_mask;
			result_q.repeat_count <= total_q;
			result_q.glyph_done   <= (pos_next == '0);
			result_q.bad_data     <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	assign status.active      = active_q;
	assign status.header_only = (run_left_q == '0) && (code_q[RUN_W-1:0] != '0);
	assign status.div_skip    = (div_cnt_q == '0)
	                          && ((n_q == '0) || (cfg.glyph_width == '0));
	assign status.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_ITERS - 1));
	assign status.slot_free   = slot_free;

endmodule
`default_nettype wire

### src/rle_glyph_expander_with_clip_top.sv
// top level of the rle glyph expander: config registers, controller and datapath
//
// usage:
//   item channel (item_valid/item_ready/item) takes one compressed glyph byte per
//   request; start_glyph marks the first byte of a glyph and reloads the position
//   count with glyph_width * row_count
//   result channel (result_valid/result_ready/result) gives one pixel byte and its
//   visible copy count per data byte, or one fill result on a zero-count header
//   cfg channel writes glyph_width, visible_width, row_count, invert by index;
//   it is always ready; it must be written only while the block is idle, unchecked
// timing:
//   one request at a time; a header or idle byte ends after the decode state; a
//   data byte passes wrap and part, the divider and multiply if needed, and the
//   output state; the 8-step radix-4 divider splits the covered positions into
//   whole rows and a remainder; the result sits in an output register, so the
//   next request is taken while a result still waits; a stalled receiver holds
//   the block only once the next result is ready to go out
// reset:
//   arst_n clears the run, column, position count and active flag, empties the
//   output register and loads the register defaults (8, 8, 1, no invert)
`default_nettype none
module rle_glyph_expander_with_clip_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                item_valid,
	output logic                               item_ready,
	input  rgx_pkg::item_t                     item,
	output logic                               result_valid,
	input  wire                                result_ready,
	output rgx_pkg::result_t                   result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [rgx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [rgx_pkg::BYTE_W-1:0]         cfg_data
);
	import rgx_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	// config writes land at once, the port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width   <= GW_RESET;
			cfg_q.visible_width <= VW_RESET;
			cfg_q.row_count     <= RC_RESET;
			cfg_q.invert        <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GLYPH_WIDTH:   cfg_q.glyph_width   <= cfg_data;
				REG_VISIBLE_WIDTH: cfg_q.visible_width <= cfg_data;
				REG_ROW_COUNT:     cfg_q.row_count     <= cfg_data;
				REG_INVERT:        cfg_q.invert        <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// sequencing of one request
	rgx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// run state, coverage math and the output register
	rgx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	// a fill result always closes the glyph
	a_bad_ends_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.bad_data) |-> result.glyph_done)
		else $error("bad_data result without glyph_done");

	// after a result is loaded the glyph stays open exactly when it is not done
	a_done_clears_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (result.glyph_done != status.active))
		else $error("glyph_done and active flag disagree");

	// the divider never runs against a zero row width
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (cfg_q.glyph_width != '0))
		else $error("division step with zero glyph width");

endmodule
`default_nettype wire
